### design/ppm_pkg.sv
// shared constants and types for the ppm frame decoder
`default_nettype none
package ppm_pkg;

  // slot count default
  localparam int unsigned NumSlotsDef = 8;

  // field widths
  localparam int unsigned TimeW  = 16;
  localparam int unsigned ValueW = 15;
  localparam int unsigned ChanW  = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // packed stream widths
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  // register reset values
  localparam logic [TimeW-1:0]  TimerTopRst   = 16'd40000;
  localparam logic [TimeW-1:0]  SyncThrRst    = 16'd8000;
  localparam logic [ValueW-1:0] ClampLowRst   = 15'd1000;
  localparam logic [ValueW-1:0] ClampHighRst  = 15'd2000;
  localparam logic [TimeW-1:0]  SlotWidthRst  = 16'd2400;

  // item kinds
  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_READ    = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMER_TOP  = 2'd0,
    REG_SYNC_THR   = 2'd1,
    REG_CLAMP_LOW  = 2'd2,
    REG_CLAMP_HIGH = 2'd3
  } cfg_reg_e;

endpackage
`default_nettype wire

### design/ppm_frame_decoder.sv
// RC PPM frame decoder: capture timestamps in, channel widths out
//
// Takes one item per clock unless stalled. Each item goes in a single pass
// from port to result register: a capture computes the interval since the
// last capture (modulo the timer top), compares it with the sync threshold
// and, unless sync or frame full, writes the next slot; a read selects one
// slot, halves and clamps it. Each accepted item gives one result the next
// cycle. The input is ready when the result register is empty or being taken,
// so a stalled result holds the input back by exactly that one register.
`default_nettype none
module ppm_frame_decoder #(
  parameter int unsigned NUM_SLOTS = ppm_pkg::NumSlotsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [ppm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ppm_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] capture_time, [18:16] read_channel, [23:19] zero
  input  wire logic [ppm_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] operation
  input  wire logic                          s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [14:0] channel_value, [15] frame_ready
  output logic [ppm_pkg::OutDataW-1:0]       m_axis_tdata
);

  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned TW   = ppm_pkg::TimeW;
  localparam int unsigned VW   = ppm_pkg::ValueW;

  // configuration registers
  logic [TW-1:0] timer_top_q, sync_thr_q;
  logic [VW-1:0] clamp_low_q, clamp_high_q;

  // decoder state
  logic [TW-1:0]   last_cap_q, last_cap_d;
  logic [CntW-1:0] slot_cnt_q, slot_cnt_d;
  logic [TW-1:0]   slot_q [NUM_SLOTS];
  logic            ready_q, ready_d;

  // result register
  logic                 out_valid_q;
  logic [VW-1:0]        out_value_q, out_value_d;
  logic                 out_flag_q, out_flag_d;

  // input fields
  logic [TW-1:0]        in_time;
  logic [ppm_pkg::ChanW-1:0] in_chan;
  ppm_pkg::op_e         in_op;
  logic                 in_acc;

  // per-item work signals
  logic [TW-1:0] interval;
  logic          is_sync;
  logic          slot_we;
  logic [TW-1:0] rd_width;
  logic [VW-1:0] half_width;

  assign in_time = s_axis_tdata[TW-1:0];
  assign in_chan = s_axis_tdata[TW +: ppm_pkg::ChanW];
  assign in_op   = ppm_pkg::op_e'(s_axis_tuser);

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_flag_q, out_value_q};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_top_q  <= ppm_pkg::TimerTopRst;
      sync_thr_q   <= ppm_pkg::SyncThrRst;
      clamp_low_q  <= ppm_pkg::ClampLowRst;
      clamp_high_q <= ppm_pkg::ClampHighRst;
    end else if (cfg_we_i) begin
      case (ppm_pkg::cfg_reg_e'(cfg_idx_i))
        ppm_pkg::REG_TIMER_TOP:  timer_top_q  <= cfg_data_i;
        ppm_pkg::REG_SYNC_THR:   sync_thr_q   <= cfg_data_i;
        ppm_pkg::REG_CLAMP_LOW:  clamp_low_q  <= cfg_data_i[VW-1:0];
        ppm_pkg::REG_CLAMP_HIGH: clamp_high_q <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  // interval since the last capture, wrapped at the timer top
  always_comb begin
    interval = in_time - last_cap_q;
    if (in_time < last_cap_q) begin
      interval = interval + timer_top_q;
    end
  end

  assign is_sync = (interval > sync_thr_q);

  // slot read mux, channels past the last slot read as zero
  always_comb begin
    rd_width = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (int'(in_chan) == i) begin
        rd_width = slot_q[i];
      end
    end
  end

  assign half_width = rd_width[TW-1:1];

  // next state and result for the item at the port
  always_comb begin
    last_cap_d  = last_cap_q;
    slot_cnt_d  = slot_cnt_q;
    ready_d     = ready_q;
    slot_we     = 1'b0;
    out_value_d = '0;
    out_flag_d  = ready_q;
    case (in_op)
      ppm_pkg::OP_CAPTURE: begin
        last_cap_d = in_time;
        if (is_sync) begin
          slot_cnt_d = '0;
          ready_d    = 1'b1;
        end else if (int'(slot_cnt_q) < NUM_SLOTS) begin
          slot_we    = 1'b1;
          slot_cnt_d = slot_cnt_q + CntW'(1);
          if (int'(slot_cnt_d) >= NUM_SLOTS) begin
            ready_d = 1'b1;
          end
        end
        out_flag_d = ready_d;
      end
      ppm_pkg::OP_READ: begin
        ready_d = 1'b0;
        if (half_width < clamp_low_q) begin
          out_value_d = clamp_low_q;
        end else if (half_width > clamp_high_q) begin
          out_value_d = clamp_high_q;
        end else begin
          out_value_d = half_width;
        end
      end
      default: ;
    endcase
  end

  // state update on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cap_q <= '0;
      slot_cnt_q <= '0;
      ready_q    <= 1'b0;
    end else if (in_acc) begin
      last_cap_q <= last_cap_d;
      slot_cnt_q <= slot_cnt_d;
      ready_q    <= ready_d;
    end
  end

  // slot widths, written at the running slot count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_q[i] <= ppm_pkg::SlotWidthRst;
      end
    end else if (in_acc && slot_we) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (int'(slot_cnt_q) == i) begin
          slot_q[i] <= interval;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_value_q <= out_value_d;
      out_flag_q  <= out_flag_d;
    end
  end

  // slot count never runs past the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(slot_cnt_q) <= NUM_SLOTS)
    else $error("slot count beyond frame length");

  // a read clears the ready flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_op == ppm_pkg::OP_READ) |=> !ready_q)
    else $error("ready flag not cleared by read");

  // a capture reports the updated flag and a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_op == ppm_pkg::OP_CAPTURE) |=>
      (out_flag_q == ready_q) && (out_value_q == '0))
    else $error("capture result mismatch");

  // every accepted item leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted item produced no result");

endmodule
`default_nettype wire
